>>> hw/rtl/amseq_pkg.sv
// Shared types, codes and reset values for the attitude mode sequencer.
`timescale 1ns / 1ps
`default_nettype none
package amseq_pkg;

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [3:0] STABLE_RUN_LEN = 4'd10;
  localparam logic [3:0] STABLE_CNT_MAX = 4'd15;

  localparam logic [1:0] SUN_FOUND   = 2'd0;
  localparam logic [1:0] SUN_ECLIPSE = 2'd2;

  typedef enum logic [2:0] {
    MODE_DEFAULT    = 3'd0,
    MODE_WAIT_EN    = 3'd1,
    MODE_DETUMBLE   = 3'd2,
    MODE_WAIT_ATT   = 3'd3,
    MODE_REORIENT   = 3'd4,
    MODE_STAB_NOSUN = 3'd5,
    MODE_STAB       = 3'd6
  } mode_t;

  typedef enum logic [1:0] {
    WHEEL_HOLD    = 2'd0,
    WHEEL_SPIN_UP = 2'd1,
    WHEEL_STOP    = 2'd2
  } wheel_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DETUMBLE_EXIT = 4'd0,
    CFG_RETUMBLE      = 4'd1,
    CFG_DRIFT_STABLE  = 4'd2,
    CFG_DRIFT_LOST    = 4'd3,
    CFG_POINT_OK      = 4'd4,
    CFG_POINT_LOST    = 4'd5,
    CFG_SUN_CLEAR     = 4'd6,
    CFG_SUN_BLOCKED   = 4'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [23:0] detumble_exit_rate;
    logic [23:0] retumble_rate;
    logic [31:0] drift_stable_limit;
    logic [31:0] drift_lost_limit;
    logic [15:0] point_ok_angle;
    logic [15:0] point_lost_angle;
    logic [15:0] sun_clear_angle;
    logic [15:0] sun_blocked_angle;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    detumble_exit_rate: 24'd9151,
    retumble_rate:      24'd52429,
    drift_stable_limit: 32'd171799,
    drift_lost_limit:   32'd429497,
    point_ok_angle:     16'd1792,
    point_lost_angle:   16'd3072,
    sun_clear_angle:    16'd8192,
    sun_blocked_angle:  16'd7680
  };

  typedef struct packed {
    logic        enable;
    logic [23:0] raw_rate;
    logic [23:0] corrected_rate;
    logic [31:0] drift_norm;
    logic [1:0]  sun_state;
    logic [15:0] sun_angle;
    logic [15:0] point_error;
  } item_t;

  typedef struct packed {
    mode_t      mode;
    logic [3:0] stable_count;
    logic       ctrl_fresh;
    logic       reset_integ;
  } state_t;

  typedef struct packed {
    mode_t      run_mode;
    logic       first_step_flag;
    logic       reset_integ_flag;
    mode_t      next_mode;
    logic       rods_clear;
    wheel_t     wheel_cmd;
    logic [3:0] stable_run;
  } result_t;

endpackage
`default_nettype wire

>>> hw/rtl/amseq_cfg.sv
// Threshold register file written through the configuration port.
`timescale 1ns / 1ps
`default_nettype none
module amseq_cfg
  import amseq_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  wr_en,
  input  wire logic [CFG_IDX_W-1:0]  wr_index,
  input  wire logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (cfg_idx_t'(wr_index))
        CFG_DETUMBLE_EXIT: cfg_nxt.detumble_exit_rate = wr_data[23:0];
        CFG_RETUMBLE:      cfg_nxt.retumble_rate      = wr_data[23:0];
        CFG_DRIFT_STABLE:  cfg_nxt.drift_stable_limit = wr_data[31:0];
        CFG_DRIFT_LOST:    cfg_nxt.drift_lost_limit   = wr_data[31:0];
        CFG_POINT_OK:      cfg_nxt.point_ok_angle     = wr_data[15:0];
        CFG_POINT_LOST:    cfg_nxt.point_lost_angle   = wr_data[15:0];
        CFG_SUN_CLEAR:     cfg_nxt.sun_clear_angle    = wr_data[15:0];
        CFG_SUN_BLOCKED:   cfg_nxt.sun_blocked_angle  = wr_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

>>> hw/rtl/amseq_step.sv
// Mode transition, stable counting and actuator events for one request.
`timescale 1ns / 1ps
`default_nettype none
module amseq_step
  import amseq_pkg::*;
(
  input  wire state_t  st,
  input  wire cfg_t    cfg,
  input  wire item_t   item,
  output state_t       st_nxt,
  output result_t      res
);

  mode_t      mode_nxt;
  logic [3:0] cnt_run;
  logic       ri_done;

  // next state
  always_comb begin
    mode_nxt = st.mode;
    cnt_run  = st.stable_count;
    ri_done  = 1'b0;
    unique case (st.mode)
      MODE_DEFAULT: begin
        mode_nxt = MODE_DETUMBLE;
      end
      MODE_WAIT_EN: begin
        if (item.enable) mode_nxt = MODE_DETUMBLE;
      end
      MODE_DETUMBLE: begin
        if (item.raw_rate < cfg.detumble_exit_rate) mode_nxt = MODE_WAIT_ATT;
      end
      MODE_WAIT_ATT: begin
        if (item.drift_norm < cfg.drift_stable_limit && item.sun_state == SUN_FOUND) begin
          if (st.stable_count != STABLE_CNT_MAX) cnt_run = st.stable_count + 4'd1;
        end else begin
          cnt_run = '0;
        end
        if (cnt_run >= STABLE_RUN_LEN) mode_nxt = MODE_REORIENT;
      end
      MODE_REORIENT: begin
        if (item.point_error < cfg.point_ok_angle) begin
          mode_nxt = MODE_STAB_NOSUN;
          ri_done  = 1'b1;
        end
      end
      MODE_STAB_NOSUN: begin
        if (item.sun_state != SUN_ECLIPSE && item.sun_angle > cfg.sun_clear_angle) begin
          mode_nxt = MODE_STAB;
        end
      end
      default: ;
    endcase

    // reverse checks, lowest priority first
    if (st.mode >= MODE_STAB &&
        (item.sun_state == SUN_ECLIPSE || item.sun_angle < cfg.sun_blocked_angle)) begin
      mode_nxt = MODE_STAB_NOSUN;
    end
    if (st.mode >= MODE_STAB_NOSUN && item.point_error > cfg.point_lost_angle) begin
      mode_nxt = MODE_REORIENT;
    end
    if (st.mode >= MODE_REORIENT && item.drift_norm > cfg.drift_lost_limit) begin
      mode_nxt = MODE_WAIT_ATT;
    end
    if (st.mode >= MODE_WAIT_ATT && item.corrected_rate > cfg.retumble_rate) begin
      mode_nxt = MODE_DETUMBLE;
    end
  end

  // outputs and events
  always_comb begin
    res.run_mode         = st.mode;
    res.first_step_flag  = 1'b0;
    res.reset_integ_flag = 1'b0;
    res.next_mode        = mode_nxt;
    res.rods_clear       = 1'b0;
    res.wheel_cmd        = WHEEL_HOLD;

    st_nxt.mode          = mode_nxt;
    st_nxt.stable_count  = cnt_run;
    st_nxt.ctrl_fresh    = st.ctrl_fresh;
    st_nxt.reset_integ   = st.reset_integ;

    unique case (st.mode) inside
      MODE_REORIENT: begin
        res.first_step_flag = st.ctrl_fresh;
        st_nxt.ctrl_fresh   = 1'b0;
      end
      MODE_STAB_NOSUN, MODE_STAB: begin
        res.first_step_flag  = st.ctrl_fresh;
        res.reset_integ_flag = st.reset_integ;
        st_nxt.ctrl_fresh    = 1'b0;
        st_nxt.reset_integ   = 1'b0;
      end
      default: ;
    endcase

    if (ri_done) st_nxt.reset_integ = 1'b1;

    if (mode_nxt != st.mode) begin
      if (st.mode == MODE_DETUMBLE || st.mode == MODE_STAB_NOSUN || st.mode == MODE_STAB) begin
        res.rods_clear = 1'b1;
      end
      unique case (mode_nxt) inside
        MODE_DETUMBLE: begin
          res.wheel_cmd = WHEEL_SPIN_UP;
        end
        MODE_WAIT_ATT: begin
          st_nxt.stable_count = '0;
          res.wheel_cmd       = WHEEL_STOP;
          res.rods_clear      = 1'b1;
        end
        MODE_REORIENT: begin
          st_nxt.ctrl_fresh  = 1'b1;
          st_nxt.reset_integ = 1'b1;
        end
        MODE_STAB_NOSUN, MODE_STAB: begin
          st_nxt.ctrl_fresh = 1'b1;
        end
        default: ;
      endcase
    end

    res.stable_run = st_nxt.stable_count;
  end

endmodule
`default_nettype wire

>>> hw/rtl/attitude_mode_sequencer.sv
// Top level of the attitude mode sequencer: request and result registers, mode state.
// One request per control iteration is accepted in every cycle while in_stall is low;
// the request lands in an input register, and the mode logic (a handful of threshold
// compares and a saturating 4-bit stable counter) runs on it and updates the mode state
// as the result is loaded into the result register, which happens when that register is
// empty or not stalled. A stalled result holds only the request behind it.
// Thresholds reset to their defaults; the user must write them through the cfg_ port
// only while no request is in flight, and the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
module attitude_mode_sequencer
  import amseq_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,

  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,

  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_enable,
  input  wire logic [23:0]           in_raw_rate,
  input  wire logic [23:0]           in_corrected_rate,
  input  wire logic [31:0]           in_drift_norm,
  input  wire logic [1:0]            in_sun_state,
  input  wire logic [15:0]           in_sun_angle,
  input  wire logic [15:0]           in_point_error,

  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [2:0]                 out_run_mode,
  output logic                       out_first_step_flag,
  output logic                       out_reset_integ_flag,
  output logic [2:0]                 out_next_mode,
  output logic                       out_rods_clear,
  output logic [1:0]                 out_wheel_cmd,
  output logic [3:0]                 out_stable_run
);

  cfg_t    cfg;
  item_t   req_r, req_nxt;
  logic    req_valid_r, req_valid_nxt;
  state_t  st_r, st_nxt, st_step;
  result_t res_r, res_nxt, res_step;
  logic    out_valid_r, out_valid_nxt;
  logic    in_accept;
  logic    advance;

  amseq_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_wr_en),
    .wr_index (cfg_index),
    .wr_data  (cfg_wr_data),
    .cfg      (cfg)
  );

  amseq_step u_step (
    .st     (st_r),
    .cfg    (cfg),
    .item   (req_r),
    .st_nxt (st_step),
    .res    (res_step)
  );

  assign advance   = req_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = req_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    req_valid_nxt = in_accept || (req_valid_r && !advance);
    out_valid_nxt = advance || (out_valid_r && out_stall);
    req_nxt       = in_accept ? item_t'{in_enable, in_raw_rate, in_corrected_rate,
                                        in_drift_norm, in_sun_state, in_sun_angle,
                                        in_point_error} : req_r;
    st_nxt        = advance ? st_step : st_r;
    res_nxt       = advance ? res_step : res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '{mode: MODE_WAIT_EN, stable_count: 4'd0,
                       ctrl_fresh: 1'b1, reset_integ: 1'b1};
    end else begin
      req_valid_r <= req_valid_nxt;
      out_valid_r <= out_valid_nxt;
      st_r        <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    res_r <= res_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_run_mode         = res_r.run_mode;
  assign out_first_step_flag  = res_r.first_step_flag;
  assign out_reset_integ_flag = res_r.reset_integ_flag;
  assign out_next_mode        = res_r.next_mode;
  assign out_rods_clear       = res_r.rods_clear;
  assign out_wheel_cmd        = res_r.wheel_cmd;
  assign out_stable_run       = res_r.stable_run;

  a_wheel_needs_change: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (res_r.wheel_cmd == WHEEL_HOLD || res_r.next_mode != res_r.run_mode))
    else $error("wheel command without a mode change");

  a_rods_need_change: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!res_r.rods_clear || res_r.next_mode != res_r.run_mode))
    else $error("rod clear without a mode change");

  a_first_step_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.first_step_flag) |->
      (res_r.run_mode == MODE_REORIENT || res_r.run_mode == MODE_STAB_NOSUN ||
       res_r.run_mode == MODE_STAB))
    else $error("first-step flag outside a controller mode");

  a_state_follows_result: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> (st_r.mode == res_r.next_mode && st_r.stable_count == res_r.stable_run))
    else $error("mode state differs from reported next mode");

endmodule
`default_nettype wire
